FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clock, skipped while reset is high.
`define SDT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge of clock, also during reset.
`define SDT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/sdt_pkg.sv
// ---------------------------------------------------------------------------
// sdt_pkg
// Types, constants and helpers of the station keeping thrust block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdt_pkg;

   localparam int QUO_BITS = 30;
   localparam int NUM_BITS = 64;
   localparam int DEN_BITS = 34;

   localparam int SIN_A = 25736;
   localparam int SIN_B = 10512;
   localparam int SIN_C = 1160;
   localparam int ONE_Q14 = 16384;

   localparam logic [1:0] CSR_TURN_GAIN = 2'd0;
   localparam logic [1:0] CSR_THRUST_GAIN = 2'd1;
   localparam logic [1:0] CSR_COMMAND_LIMIT = 2'd2;

   // Data that rides beside the divider.
   typedef struct packed {
      logic vld;
      logic at_target;
      logic neg;
      logic signed [15:0] thr;
   } side_type;

   function automatic logic signed [15:0] clamp_cmd(input logic signed [63:0] v,
                                                    input logic [14:0] lim);
      logic signed [63:0] l;
      l = 64'($signed({1'b0, lim}));
      if (v > l) begin
         return 16'(l);
      end else if (v < -l) begin
         return 16'(-l);
      end
      return 16'(v);
   endfunction

endpackage

FILE: hw/rtl/station_keep_diff_thrust.sv
// ---------------------------------------------------------------------------
// station_keep_diff_thrust
// Station keeping law for a vessel with two differential thrusters.
// ---------------------------------------------------------------------------
// Usage: each request carries the vessel position, heading and hold point.
// The block returns one response per request with the clamped turn and
// thrust commands, the mixed left and right motor commands and a flag that
// is set when the vessel sits exactly on the hold point.
// Channels: req_valid/req_stall in, rsp_valid/rsp_stall out, csr_valid/
// csr_ready for the gain and limit registers (always ready).
// The pipeline has 11 stages for the sine polynomial, products and
// normalization, 30 stages of the one bit per stage divider, and two
// stages for the turn gain and the motor mixing. Throughput is one
// request per cycle, but none is taken while a held response stalls.
// When rsp_stall holds a valid response, the whole pipeline freezes and
// req_stall is raised; nothing is lost or repeated. Reset empties the
// pipeline and loads turn_gain 0, thrust_gain 0 and command_limit 9600.
// The user writes registers only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module station_keep_diff_thrust #(
   parameter int POS_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_BITS-1:0]  req_pos_east,
   input  logic signed [POS_BITS-1:0]  req_pos_north,
   input  logic [15:0]                 req_heading,
   input  logic signed [POS_BITS-1:0]  req_hold_east,
   input  logic signed [POS_BITS-1:0]  req_hold_north,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_turn_cmd,
   output logic signed [15:0]          rsp_thrust_cmd,
   output logic signed [15:0]          rsp_left_motor,
   output logic signed [15:0]          rsp_right_motor,
   output logic                        rsp_at_target,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [23:0]                 csr_wdata
);
   import sdt_pkg::*;

   localparam int D_W = POS_BITS + 1;
   localparam int K_MAX = D_W - 16;
   localparam int K_W = $clog2(K_MAX + 1) + 1;
   localparam int HB_W = $clog2(D_W + 1);
   localparam int PX_W = D_W + 17;
   localparam int DOT_W = D_W + 18;
   localparam int DQ_W = DOT_W - 14;
   localparam int TP_W = DQ_W + 24;
   localparam int TH_W = TP_W - 16;
   localparam int PRE = 11;

   // Configuration registers.
   logic signed [23:0] turn_gain_ff, thrust_gain_ff;
   logic [14:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_gain_ff <= '0;
         thrust_gain_ff <= '0;
         limit_ff <= 15'd9600;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TURN_GAIN: turn_gain_ff <= csr_wdata;
            CSR_THRUST_GAIN: thrust_gain_ff <= csr_wdata;
            CSR_COMMAND_LIMIT: limit_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together unless the output is held.
   logic en;
   logic rsp_valid_ff;
   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   logic vld_ff [PRE];
   logic at_ff [PRE];

   // Stage 1
   logic signed [D_W-1:0] dx1_ff, dy1_ff;
   logic [15:0] a1_ff;
   // Stage 2
   logic signed [D_W-1:0] dx2_ff, dy2_ff;
   logic [D_W-1:0] mx2_ff, my2_ff;
   logic [14:0] ts2_ff, tc2_ff;
   logic [1:0] q2_ff;
   // Stage 3
   logic signed [D_W-1:0] dx3_ff, dy3_ff;
   logic [D_W-1:0] mx3_ff, my3_ff;
   logic [K_W-1:0] k3_ff;
   logic [14:0] ts3_ff, tc3_ff;
   logic [15:0] t2s3_ff, t2c3_ff;
   logic [1:0] q3_ff;
   // Stage 4
   logic signed [D_W-1:0] dx4_ff, dy4_ff;
   logic signed [16:0] nx4_ff, ny4_ff;
   logic [14:0] ts4_ff, tc4_ff;
   logic [15:0] t2s4_ff, t2c4_ff;
   logic [13:0] ins4_ff, inc4_ff;
   logic [1:0] q4_ff;
   // Stage 5
   logic signed [D_W-1:0] dx5_ff, dy5_ff;
   logic signed [16:0] nx5_ff, ny5_ff;
   logic [14:0] ts5_ff, tc5_ff;
   logic [14:0] mds5_ff, mdc5_ff;
   logic [1:0] q5_ff;
   // Stage 6
   logic signed [D_W-1:0] dx6_ff, dy6_ff;
   logic signed [16:0] nx6_ff, ny6_ff;
   logic signed [16:0] s6_ff, c6_ff;
   logic [1:0] q6_ff;
   // Stage 7
   logic signed [D_W-1:0] dx7_ff, dy7_ff;
   logic signed [16:0] nx7_ff, ny7_ff;
   logic signed [16:0] ux7_ff, uy7_ff;
   // Stage 8
   logic signed [PX_W-1:0] px8_ff, py8_ff;
   logic signed [33:0] ax8_ff, ay8_ff, bx8_ff, by8_ff, nxx8_ff, nyy8_ff;
   // Stage 9
   logic signed [DOT_W-1:0] dot9_ff;
   logic signed [34:0] dotn9_ff, cross9_ff;
   logic [DEN_BITS-1:0] den9_ff;
   // Stage 10
   logic signed [DQ_W-1:0] dq10_ff;
   logic [31:0] mdot10_ff, mcr10_ff;
   logic neg10_ff;
   logic [DEN_BITS-1:0] den10_ff;
   // Stage 11
   logic signed [TP_W-1:0] tp11_ff;
   logic [NUM_BITS-1:0] num11_ff;
   logic [DEN_BITS-1:0] den11_ff;
   logic neg11_ff;

   // Combinational helpers.
   logic [15:0] a_in;
   logic [13:0] f_in;
   logic [D_W-1:0] m_in;
   logic [HB_W-1:0] hb_in;
   logic [K_W-1:0] k_in;
   logic [D_W-1:0] shx_in, shy_in;
   logic [31:0] ps_t2, pc_t2, ps_c, pc_c, ps_i, pc_i, ps_m, pc_m;
   logic signed [16:0] ux_in, uy_in;
   logic [DOT_W-1:0] mdot_in;
   logic [DQ_W-1:0] dqm_in;
   logic [TP_W-1:0] tpm_in;
   logic signed [TH_W-1:0] th_in;
   logic signed [34:0] mdn_in, mcr_in;

   assign a_in = 16'(a1_ff);
   assign f_in = a1_ff[13:0];

   assign ps_t2 = 32'(ts2_ff) * 32'(ts2_ff);
   assign pc_t2 = 32'(tc2_ff) * 32'(tc2_ff);
   assign ps_c = 32'(t2s3_ff) * 32'(SIN_C);
   assign pc_c = 32'(t2c3_ff) * 32'(SIN_C);
   assign ps_i = 32'(t2s4_ff) * 32'(ins4_ff);
   assign pc_i = 32'(t2c4_ff) * 32'(inc4_ff);
   assign ps_m = 32'(ts5_ff) * 32'(mds5_ff);
   assign pc_m = 32'(tc5_ff) * 32'(mdc5_ff);

   // Leading one of the larger offset magnitude sets the normalizing shift.
   always_comb begin
      m_in = (mx2_ff > my2_ff) ? mx2_ff : my2_ff;
      hb_in = '0;
      for (int j = 0; j < D_W; j++) begin
         if (m_in[j]) begin
            hb_in = HB_W'(j + 1);
         end
      end
      k_in = (hb_in > HB_W'(16)) ? K_W'(hb_in - HB_W'(16)) : '0;
   end

   assign shx_in = mx3_ff >> k3_ff;
   assign shy_in = my3_ff >> k3_ff;

   always_comb begin
      case (q6_ff)
         2'd0: begin ux_in = c6_ff; uy_in = s6_ff; end
         2'd1: begin ux_in = -s6_ff; uy_in = c6_ff; end
         2'd2: begin ux_in = -c6_ff; uy_in = -s6_ff; end
         default: begin ux_in = s6_ff; uy_in = -c6_ff; end
      endcase
   end

   assign mdot_in = dot9_ff[DOT_W-1] ? DOT_W'(-dot9_ff) : DOT_W'(dot9_ff);
   assign dqm_in = DQ_W'(mdot_in >> 14);
   assign mdn_in = dotn9_ff[34] ? -dotn9_ff : dotn9_ff;
   assign mcr_in = cross9_ff[34] ? -cross9_ff : cross9_ff;

   assign tpm_in = tp11_ff[TP_W-1] ? TP_W'(-tp11_ff) : TP_W'(tp11_ff);
   assign th_in = tp11_ff[TP_W-1] ? -$signed(TH_W'(tpm_in >> 16))
                                  : $signed(TH_W'(tpm_in >> 16));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PRE; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int j = 1; j < PRE; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Stage 1: offsets and scaled angle.
         dx1_ff <= D_W'(req_pos_east) - D_W'(req_hold_east);
         dy1_ff <= D_W'(req_pos_north) - D_W'(req_hold_north);
         a1_ff <= 16'(req_heading[ANGLE_BITS-1:0]) << (16 - ANGLE_BITS);

         // Stage 2: magnitudes and polynomial arguments.
         at_ff[0] <= 1'b0;
         at_ff[1] <= (dx1_ff == '0) && (dy1_ff == '0);
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         mx2_ff <= dx1_ff[D_W-1] ? D_W'(-dx1_ff) : D_W'(dx1_ff);
         my2_ff <= dy1_ff[D_W-1] ? D_W'(-dy1_ff) : D_W'(dy1_ff);
         ts2_ff <= 15'(f_in);
         tc2_ff <= 15'(ONE_Q14) - 15'(f_in);
         q2_ff <= a_in[15:14];

         // Stage 3: shift count and t squared.
         for (int j = 2; j < PRE; j++) begin
            at_ff[j] <= at_ff[j-1];
         end
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         mx3_ff <= mx2_ff;
         my3_ff <= my2_ff;
         k3_ff <= k_in;
         ts3_ff <= ts2_ff;
         tc3_ff <= tc2_ff;
         t2s3_ff <= 16'(ps_t2 >> 14);
         t2c3_ff <= 16'(pc_t2 >> 14);
         q3_ff <= q2_ff;

         // Stage 4: normalized offsets and inner term.
         dx4_ff <= dx3_ff;
         dy4_ff <= dy3_ff;
         nx4_ff <= dx3_ff[D_W-1] ? -$signed({1'b0, 16'(shx_in)})
                                 : $signed({1'b0, 16'(shx_in)});
         ny4_ff <= dy3_ff[D_W-1] ? -$signed({1'b0, 16'(shy_in)})
                                 : $signed({1'b0, 16'(shy_in)});
         ts4_ff <= ts3_ff;
         tc4_ff <= tc3_ff;
         t2s4_ff <= t2s3_ff;
         t2c4_ff <= t2c3_ff;
         ins4_ff <= 14'(32'(SIN_B) - (ps_c >> 14));
         inc4_ff <= 14'(32'(SIN_B) - (pc_c >> 14));
         q4_ff <= q3_ff;

         // Stage 5: middle term.
         dx5_ff <= dx4_ff;
         dy5_ff <= dy4_ff;
         nx5_ff <= nx4_ff;
         ny5_ff <= ny4_ff;
         ts5_ff <= ts4_ff;
         tc5_ff <= tc4_ff;
         mds5_ff <= 15'(32'(SIN_A) - (ps_i >> 14));
         mdc5_ff <= 15'(32'(SIN_A) - (pc_i >> 14));
         q5_ff <= q4_ff;

         // Stage 6: sine and cosine.
         dx6_ff <= dx5_ff;
         dy6_ff <= dy5_ff;
         nx6_ff <= nx5_ff;
         ny6_ff <= ny5_ff;
         s6_ff <= $signed({1'b0, 16'(ps_m >> 14)});
         c6_ff <= $signed({1'b0, 16'(pc_m >> 14)});
         q6_ff <= q5_ff;

         // Stage 7: heading vector by quadrant.
         dx7_ff <= dx6_ff;
         dy7_ff <= dy6_ff;
         nx7_ff <= nx6_ff;
         ny7_ff <= ny6_ff;
         ux7_ff <= ux_in;
         uy7_ff <= uy_in;

         // Stage 8: products.
         px8_ff <= PX_W'(ux7_ff) * PX_W'(dx7_ff);
         py8_ff <= PX_W'(uy7_ff) * PX_W'(dy7_ff);
         ax8_ff <= 34'(ux7_ff) * 34'(nx7_ff);
         ay8_ff <= 34'(uy7_ff) * 34'(ny7_ff);
         bx8_ff <= 34'(ux7_ff) * 34'(ny7_ff);
         by8_ff <= 34'(uy7_ff) * 34'(nx7_ff);
         nxx8_ff <= 34'(nx7_ff) * 34'(nx7_ff);
         nyy8_ff <= 34'(ny7_ff) * 34'(ny7_ff);

         // Stage 9: dot, cross and squared norm.
         dot9_ff <= DOT_W'(px8_ff) + DOT_W'(py8_ff);
         dotn9_ff <= 35'(ax8_ff) + 35'(ay8_ff);
         cross9_ff <= 35'(bx8_ff) - 35'(by8_ff);
         den9_ff <= DEN_BITS'($unsigned(nxx8_ff)) + DEN_BITS'($unsigned(nyy8_ff));

         // Stage 10: truncate dot toward zero, split signs from magnitudes.
         dq10_ff <= dot9_ff[DOT_W-1] ? -$signed(dqm_in) : $signed(dqm_in);
         mdot10_ff <= 32'(mdn_in);
         mcr10_ff <= 32'(mcr_in);
         neg10_ff <= dotn9_ff[34] ^ cross9_ff[34];
         den10_ff <= den9_ff;

         // Stage 11: thrust gain product and divider numerator.
         tp11_ff <= TP_W'(thrust_gain_ff) * TP_W'(dq10_ff);
         num11_ff <= NUM_BITS'(mdot10_ff) * NUM_BITS'(mcr10_ff);
         den11_ff <= den10_ff;
         neg11_ff <= neg10_ff;
      end
   end

   // Divider and its side line.
   logic [QUO_BITS-1:0] quo;
   side_type side_ff [QUO_BITS];
   side_type side_in;

   sdt_div u_div (
      .clock (clock),
      .en    (en),
      .num   (num11_ff),
      .den   (den11_ff),
      .quo   (quo)
   );

   always_comb begin
      side_in.vld = vld_ff[PRE-1];
      side_in.at_target = at_ff[PRE-1];
      side_in.neg = neg11_ff;
      side_in.thr = clamp_cmd(64'(th_in), limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QUO_BITS; j++) begin
            side_ff[j].vld <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < QUO_BITS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // Turn gain stage.
   localparam int R_W = QUO_BITS + 1;
   localparam int TG_W = R_W + 24;
   logic signed [R_W-1:0] r_in;
   logic signed [TG_W-1:0] tg_ff;
   logic tg_vld_ff, tg_at_ff;
   logic signed [15:0] tg_thr_ff;

   assign r_in = side_ff[QUO_BITS-1].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_ff @(posedge clock) begin
      if (reset) begin
         tg_vld_ff <= 1'b0;
      end else if (en) begin
         tg_vld_ff <= side_ff[QUO_BITS-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tg_ff <= TG_W'(turn_gain_ff) * TG_W'(r_in);
         tg_at_ff <= side_ff[QUO_BITS-1].at_target;
         tg_thr_ff <= side_ff[QUO_BITS-1].thr;
      end
   end

   // Output stage: turn truncation, clamp and motor mixing.
   logic [TG_W-1:0] tgm_in;
   logic signed [TG_W-37:0] tu_in;
   logic signed [15:0] turn_in;
   logic signed [16:0] sum_l, sum_r;
   logic signed [16:0] half_l, half_r;
   logic signed [15:0] turn_cmd_ff, thrust_cmd_ff, left_ff, right_ff;
   logic at_target_ff;

   assign tgm_in = tg_ff[TG_W-1] ? TG_W'(-tg_ff) : TG_W'(tg_ff);
   assign tu_in = tg_ff[TG_W-1] ? -$signed((TG_W-36)'(tgm_in >> 36))
                                : $signed((TG_W-36)'(tgm_in >> 36));
   assign turn_in = clamp_cmd(64'(tu_in), limit_ff);
   assign sum_l = 17'(tg_thr_ff) - 17'(turn_in);
   assign sum_r = 17'(tg_thr_ff) + 17'(turn_in);
   // Halving rounds toward zero, as the clamps keep both sums in range.
   assign half_l = (sum_l + 17'(sum_l[16])) >>> 1;
   assign half_r = (sum_r + 17'(sum_r[16])) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tg_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         at_target_ff <= tg_at_ff;
         if (tg_at_ff) begin
            turn_cmd_ff <= '0;
            thrust_cmd_ff <= '0;
            left_ff <= '0;
            right_ff <= '0;
         end else begin
            turn_cmd_ff <= turn_in;
            thrust_cmd_ff <= tg_thr_ff;
            left_ff <= 16'(half_l);
            right_ff <= 16'(half_r);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_turn_cmd = turn_cmd_ff;
   assign rsp_thrust_cmd = thrust_cmd_ff;
   assign rsp_left_motor = left_ff;
   assign rsp_right_motor = right_ff;
   assign rsp_at_target = at_target_ff;

`include "assert_macros.svh"

   `SDT_ASSERT(a_target_zero, rsp_valid && rsp_at_target |-> rsp_turn_cmd == 16'sd0 &&
      rsp_thrust_cmd == 16'sd0 && rsp_left_motor == 16'sd0 && rsp_right_motor == 16'sd0,
      "at_target response carries nonzero commands")
   `SDT_ASSERT(a_turn_range, rsp_valid |-> rsp_turn_cmd != 16'sh8000 &&
      rsp_thrust_cmd != 16'sh8000, "clamped command out of range")
   `SDT_ASSERT(a_motor_range, rsp_valid |-> rsp_left_motor != 16'sh8000 &&
      rsp_right_motor != 16'sh8000, "motor command out of range")
   `SDT_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")

endmodule

FILE: hw/rtl/sdt_div.sv
// ---------------------------------------------------------------------------
// sdt_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdt_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [sdt_pkg::NUM_BITS-1:0]   num,
   input  logic [sdt_pkg::DEN_BITS-1:0]   den,
   output logic [sdt_pkg::QUO_BITS-1:0]   quo
);
   import sdt_pkg::*;

   logic [NUM_BITS-1:0] rem_ff [QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   // The quotient is known to fit in QUO_BITS, so the top bit is tried first.
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
      logic [NUM_BITS-1:0] rem_in;
      logic [DEN_BITS-1:0] den_in;
      logic [QUO_BITS-1:0] quo_in;
      logic [NUM_BITS-1:0] sub;

      if (j == 0) begin : g_first
         assign rem_in = num;
         assign den_in = den;
         assign quo_in = '0;
      end else begin : g_next
         assign rem_in = rem_ff[j-1];
         assign den_in = den_ff[j-1];
         assign quo_in = quo_ff[j-1];
      end

      assign sub = NUM_BITS'(den_in) << (QUO_BITS - 1 - j);

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[j] <= den_in;
            if (rem_in >= sub) begin
               rem_ff[j] <= rem_in - sub;
               quo_ff[j] <= quo_in | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
            end else begin
               rem_ff[j] <= rem_in;
               quo_ff[j] <= quo_in;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

FILE: tb/sv/station_keep_diff_thrust_checker.sv
// ---------------------------------------------------------------------------
// station_keep_diff_thrust_checker
// Watches the request, response and register channels, predicts each
// response from the current gains and limit, and compares field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module station_keep_diff_thrust_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [23:0] req_pos_east,
   input  logic signed [23:0] req_pos_north,
   input  logic [15:0]        req_heading,
   input  logic signed [23:0] req_hold_east,
   input  logic signed [23:0] req_hold_north,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_turn_cmd,
   input  logic signed [15:0] rsp_thrust_cmd,
   input  logic signed [15:0] rsp_left_motor,
   input  logic signed [15:0] rsp_right_motor,
   input  logic               rsp_at_target,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output int                 pending,
   output int                 failures
);
   import sdt_pkg::*;

   typedef struct packed {
      logic signed [15:0] turn;
      logic signed [15:0] thrust;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               at_target;
   } motor_cmd_type;

   motor_cmd_type expected_cmds[$];
   longint turn_gain, thrust_gain, cmd_limit;

   function automatic longint trunc_shift(longint v, int k);
      if (v < 0) return -((-v) >>> k);
      return v >>> k;
   endfunction

   function automatic longint poly_sine(longint t);
      longint t2, inner, mid;
      t2 = (t * t) >>> 14;
      inner = SIN_B - ((t2 * SIN_C) >>> 14);
      mid = SIN_A - ((t2 * inner) >>> 14);
      return (t * mid) >>> 14;
   endfunction

   function automatic longint limit_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic motor_cmd_type station_law(longint pe, longint pn, logic [15:0] hdg,
                                                 longint he, longint hn);
      motor_cmd_type res;
      longint dx, dy, ux, uy, s, c, dotp, crossp, thr, turn, left, right;
      longint nx, ny, den, r, m, lim;
      logic [13:0] f;
      int k;
      dx = pe - he;
      dy = pn - hn;
      lim = cmd_limit;
      res = '0;
      if (dx == 0 && dy == 0) begin
         res.at_target = 1'b1;
         return res;
      end
      f = hdg[13:0];
      s = poly_sine(longint'(f));
      c = poly_sine(ONE_Q14 - longint'(f));
      case (hdg[15:14])
         2'd0: begin ux = c; uy = s; end
         2'd1: begin ux = -s; uy = c; end
         2'd2: begin ux = -c; uy = -s; end
         default: begin ux = s; uy = -c; end
      endcase
      dotp = ux * dx + uy * dy;
      thr = trunc_shift(thrust_gain * trunc_shift(dotp, 14), 16);
      m = magnitude(dx) > magnitude(dy) ? magnitude(dx) : magnitude(dy);
      k = 0;
      while ((m >>> k) >= 65536) k++;
      nx = trunc_shift(dx, k);
      ny = trunc_shift(dy, k);
      dotp = ux * nx + uy * ny;
      crossp = ux * ny - uy * nx;
      den = nx * nx + ny * ny;
      r = (den != 0) ? (dotp * crossp) / den : 0;
      turn = trunc_shift(turn_gain * r, 36);
      turn = limit_to(turn, lim);
      thr = limit_to(thr, lim);
      left = (thr - turn) / 2;
      right = (thr + turn) / 2;
      m = magnitude(left) > magnitude(right) ? magnitude(left) : magnitude(right);
      if (m > lim) begin
         left = (left * lim) / m;
         right = (right * lim) / m;
      end
      res.turn = 16'(turn);
      res.thrust = 16'(thr);
      res.left = 16'(left);
      res.right = 16'(right);
      return res;
   endfunction

   always @(posedge clock) begin
      motor_cmd_type want;
      if (reset) begin
         turn_gain <= 0;
         thrust_gain <= 0;
         cmd_limit <= 9600;
         failures <= 0;
         pending <= 0;
         expected_cmds.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TURN_GAIN: turn_gain <= longint'($signed(csr_wdata));
               CSR_THRUST_GAIN: thrust_gain <= longint'($signed(csr_wdata));
               CSR_COMMAND_LIMIT: cmd_limit <= longint'(csr_wdata[14:0]);
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_cmds.push_back(station_law(req_pos_east, req_pos_north, req_heading,
                                                req_hold_east, req_hold_north));
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected response turn=%0d thrust=%0d", $time,
                        rsp_turn_cmd, rsp_thrust_cmd);
               failures <= failures + 1;
            end else begin
               want = expected_cmds.pop_front();
               if (want !== {rsp_turn_cmd, rsp_thrust_cmd, rsp_left_motor,
                             rsp_right_motor, rsp_at_target}) begin
                  $display("%0t: mismatch expected turn=%0d thrust=%0d left=%0d right=%0d at=%0b",
                           $time, want.turn, want.thrust, want.left, want.right,
                           want.at_target);
                  $display("%0t:          actual turn=%0d thrust=%0d left=%0d right=%0d at=%0b",
                           $time, rsp_turn_cmd, rsp_thrust_cmd, rsp_left_motor,
                           rsp_right_motor, rsp_at_target);
                  failures <= failures + 1;
               end
            end
         end
         pending <= expected_cmds.size();
      end
   end

endmodule

FILE: tb/sv/station_keep_diff_thrust_tb.sv
// ---------------------------------------------------------------------------
// station_keep_diff_thrust_tb
// Drives directed and random position requests through several gain and
// limit settings with random gaps and stalls; the checker does the compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module station_keep_diff_thrust_tb;
   import sdt_pkg::*;

   localparam int LATENCY = 43;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_pos_east = '0, req_pos_north = '0;
   logic signed [23:0] req_hold_east = '0, req_hold_north = '0;
   logic [15:0] req_heading = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_turn_cmd, rsp_thrust_cmd, rsp_left_motor, rsp_right_motor;
   logic rsp_at_target;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;
   int pending, failures;
   longint cycles = 0;
   bit hold_off = 1'b0;

   always #4 clock = ~clock;

   station_keep_diff_thrust uut (.*);
   station_keep_diff_thrust_checker checker_i (.*);

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // Receiver side: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         n = gap_length();
         rsp_stall <= (n != 0);
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("station_keep_diff_thrust_tb NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_position(logic [23:0] pe, logic [23:0] pn, logic [15:0] hdg,
                                logic [23:0] he, logic [23:0] hn, bit gaps);
      int n;
      req_valid <= 1'b1;
      req_pos_east <= pe;
      req_pos_north <= pn;
      req_heading <= hdg;
      req_hold_east <= he;
      req_hold_north <= hn;
      do @(posedge clock); while (req_stall);
      n = gaps ? gap_length() : 0;
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic random_batch(int count, bit wide);
      logic [23:0] he, hn, pe, pn;
      for (int i = 0; i < count; i++) begin
         he = $urandom;
         hn = $urandom;
         case ($urandom_range(0, 5))
            0: begin pe = he; pn = hn; end
            1: begin pe = $urandom; pn = $urandom; end
            2: begin pe = he + 24'($urandom_range(0, 8)) - 24'd4;
                     pn = hn + 24'($urandom_range(0, 8)) - 24'd4; end
            default: begin
               pe = wide ? he + 24'($urandom) : he + 24'($signed(16'($urandom)));
               pn = wide ? hn + 24'($urandom) : hn + 24'($signed(16'($urandom)));
            end
         endcase
         send_position(pe, pn, 16'($urandom), he, hn, 1'b1);
      end
   endtask

   initial begin
      logic [23:0] tgs[5] = '{24'h000100, 24'h7FFFFF, 24'h800000, 24'hFFFF00, 24'h001234};
      logic [23:0] sgs[5] = '{24'h000100, 24'h800000, 24'h7FFFFF, 24'hFFF000, 24'h000040};
      logic [23:0] lims[5] = '{24'd9600, 24'd32767, 24'd1, 24'd0, 24'd500};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset gains are zero: a few requests before any write.
      send_position(24'h000100, 24'h000000, 16'h0000, 24'h0, 24'h0, 1'b0);
      send_position(24'h0, 24'h0, 16'h4000, 24'h0, 24'h0, 1'b0);
      drain();
      write_reg(CSR_TURN_GAIN, 24'h010000);
      write_reg(CSR_THRUST_GAIN, 24'h000800);
      write_reg(CSR_COMMAND_LIMIT, 24'd9600);
      // Directed: field extremes, every quadrant, zero offset, large offsets.
      send_position(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 24'h800000, 24'h800000, 1'b0);
      send_position(24'h800000, 24'h800000, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_position(24'h7FFFFF, 24'h800000, 16'h4000, 24'h800000, 24'h7FFFFF, 1'b0);
      send_position(24'h000100, 24'h000000, 16'h8000, 24'h0, 24'h0, 1'b0);
      send_position(24'h000000, 24'h000100, 16'hC000, 24'h0, 24'h0, 1'b0);
      send_position(24'h000100, 24'h000100, 16'h2000, 24'h0, 24'h0, 1'b0);
      send_position(24'h123456, 24'h654321, 16'h5555, 24'h123456, 24'h654321, 1'b0);
      send_position(24'h000001, 24'h000000, 16'h3FFF, 24'h0, 24'h0, 1'b0);
      send_position(24'h000000, 24'hFFFFFF, 16'hAAAA, 24'h0, 24'h0, 1'b0);
      send_position(24'h00FFFF, 24'h010000, 16'h7FFF, 24'h0, 24'h0, 1'b0);
      send_position(24'h7FFFFF, 24'h000000, 16'h1234, 24'h7FFFFF, 24'h000001, 1'b0);
      drain();
      for (int p = 0; p < 5; p++) begin
         write_reg(CSR_TURN_GAIN, tgs[p]);
         write_reg(CSR_THRUST_GAIN, sgs[p]);
         write_reg(CSR_COMMAND_LIMIT, lims[p]);
         // The sender keeps offering while the receiver holds off.
         if (p == 1) hold_off = 1'b1;
         random_batch(140, p[0]);
         drain();
      end
      if (failures == 0) begin
         $display("station_keep_diff_thrust_tb OK");
      end else begin
         $display("station_keep_diff_thrust_tb NOT OK");
      end
      $finish;
   end

endmodule
